[hw/rtl/tspfa_pkg.sv]
// Shared types and constants of the two-size page frame allocator.
package tspfa_pkg;

    localparam int ADDR_W        = 32;

    localparam int PAGE_SLOTS    = 32768;
    localparam int SUPER_SLOTS   = 64;
    localparam int PAGE_SHIFT    = 12;
    localparam int SUPER_SHIFT   = 21;

    localparam int PAGE_FRAME_W  = ADDR_W - PAGE_SHIFT;
    localparam int SUPER_FRAME_W = ADDR_W - SUPER_SHIFT;
    localparam int FRAME_W       = (PAGE_FRAME_W > SUPER_FRAME_W) ? PAGE_FRAME_W
                                                                  : SUPER_FRAME_W;

    localparam int PAGE_IDX_W    = ($clog2(PAGE_SLOTS) > 0) ? $clog2(PAGE_SLOTS) : 1;
    localparam int SUPER_IDX_W   = ($clog2(SUPER_SLOTS) > 0) ? $clog2(SUPER_SLOTS) : 1;
    localparam int PAGE_CNT_W    = $clog2(PAGE_SLOTS + 1);
    localparam int SUPER_CNT_W   = $clog2(SUPER_SLOTS + 1);

    // decoupling queue; depth must stay a power of two so the pointers wrap
    localparam int Q_DEPTH       = 2;
    localparam int Q_PTR_W       = ($clog2(Q_DEPTH) > 0) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W       = $clog2(Q_DEPTH + 1);

    localparam int CMD_W         = 2;
    localparam int STATUS_W      = 2;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CMD_W-1:0] CMD_FREE_PAGE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE_SUPER  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ALLOC_PAGE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_ALLOC_SUPER = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADADDR = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_END  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHYS_TOP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUPER_START = 2'd2;

    localparam logic [ADDR_W-1:0] KERNEL_END_RST  = 32'h8000_0000;
    localparam logic [ADDR_W-1:0] PHYS_TOP_RST    = 32'h8800_0000;
    localparam logic [ADDR_W-1:0] SUPER_START_RST = 32'h8600_0000;

    typedef enum logic [2:0] {
        OP_PUSH_PAGE,
        OP_PUSH_SUPER,
        OP_POP_PAGE,
        OP_POP_SUPER,
        OP_BAD
    } t_op_kind;

    typedef struct packed {
        t_op_kind             kind;
        logic [FRAME_W-1:0]   frame;
    } t_op;

    typedef enum logic [0:0] {
        BK_IDLE,
        BK_READ
    } t_back_state;

endpackage

[hw/rtl/tspfa_front.sv]
// Front end: range registers, command decode and address checks.
module tspfa_front
    import tspfa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ADDR_W-1:0]    i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic [ADDR_W-1:0]    i_addr,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_op                  o_op
);

    logic [ADDR_W-1:0] r_kernel_end;
    logic [ADDR_W-1:0] r_phys_top;
    logic [ADDR_W-1:0] r_super_start;

    logic page_bad;
    logic super_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_end  <= KERNEL_END_RST;
            r_phys_top    <= PHYS_TOP_RST;
            r_super_start <= SUPER_START_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KERNEL_END:  r_kernel_end  <= i_cfg_data;
                CFG_PHYS_TOP:    r_phys_top    <= i_cfg_data;
                CFG_SUPER_START: r_super_start <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign page_bad  = (i_addr[PAGE_SHIFT-1:0] != '0) || (i_addr < r_kernel_end) ||
                       (i_addr >= r_phys_top);
    assign super_bad = (i_addr[SUPER_SHIFT-1:0] != '0) || (i_addr < r_super_start) ||
                       (i_addr >= r_phys_top);

    always_comb begin
        o_op.frame = '0;
        case (i_cmd)
            CMD_FREE_PAGE: begin
                o_op.kind  = page_bad ? OP_BAD : OP_PUSH_PAGE;
                o_op.frame = FRAME_W'(i_addr >> PAGE_SHIFT);
            end
            CMD_FREE_SUPER: begin
                o_op.kind  = super_bad ? OP_BAD : OP_PUSH_SUPER;
                o_op.frame = FRAME_W'(i_addr >> SUPER_SHIFT);
            end
            CMD_ALLOC_PAGE: o_op.kind = OP_POP_PAGE;
            default:        o_op.kind = OP_POP_SUPER;
        endcase
    end

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

endmodule

[hw/rtl/tspfa_queue.sv]
// Short FIFO of decoded operations between front and back end.
module tspfa_queue
    import tspfa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_op  o_op
);

    t_op                r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_op    = r_slot[r_rd_ptr];

endmodule

[hw/rtl/tspfa_back.sv]
// Back end: the two frame stacks, their counts and the result register.
module tspfa_back
    import tspfa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  t_op                 i_q_op,
    output logic                o_q_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [ADDR_W-1:0]   o_frame_addr
);

    logic [PAGE_FRAME_W-1:0]  r_page_mem  [PAGE_SLOTS];
    logic [SUPER_FRAME_W-1:0] r_super_mem [SUPER_SLOTS];
    logic [PAGE_FRAME_W-1:0]  r_page_rd;
    logic [SUPER_FRAME_W-1:0] r_super_rd;

    t_back_state            r_state;
    t_back_state            n_state;
    logic [PAGE_CNT_W-1:0]  r_page_cnt;
    logic [PAGE_CNT_W-1:0]  n_page_cnt;
    logic [SUPER_CNT_W-1:0] r_super_cnt;
    logic [SUPER_CNT_W-1:0] n_super_cnt;
    logic                   r_rd_super;

    logic                   r_out_valid;
    logic [STATUS_W-1:0]    r_out_status;
    logic [ADDR_W-1:0]      r_out_frame;

    logic                   out_free;
    logic                   ld_out;
    logic [STATUS_W-1:0]    ld_status;
    logic [ADDR_W-1:0]      ld_frame;
    logic                   page_we;
    logic                   page_re;
    logic                   super_we;
    logic                   super_re;
    logic [PAGE_IDX_W-1:0]  page_idx;
    logic [SUPER_IDX_W-1:0] super_idx;

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid && out_free) begin
                    if ((i_q_op.kind == OP_POP_PAGE && r_page_cnt != '0) ||
                        (i_q_op.kind == OP_POP_SUPER && r_super_cnt != '0)) begin
                        n_state = BK_READ;
                    end
                end
            end
            BK_READ: begin
                if (out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop     = 1'b0;
        ld_out      = 1'b0;
        ld_status   = ST_OK;
        ld_frame    = '0;
        page_we     = 1'b0;
        page_re     = 1'b0;
        super_we    = 1'b0;
        super_re    = 1'b0;
        n_page_cnt  = r_page_cnt;
        n_super_cnt = r_super_cnt;
        page_idx    = r_page_cnt[PAGE_IDX_W-1:0];
        super_idx   = r_super_cnt[SUPER_IDX_W-1:0];
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_q_pop = 1'b1;
                    case (i_q_op.kind)
                        OP_PUSH_PAGE: begin
                            ld_out = 1'b1;
                            if (r_page_cnt >= PAGE_CNT_W'(PAGE_SLOTS)) begin
                                ld_status = ST_FULL;
                            end else begin
                                page_we    = 1'b1;
                                n_page_cnt = r_page_cnt + 1'b1;
                            end
                        end
                        OP_PUSH_SUPER: begin
                            ld_out = 1'b1;
                            if (r_super_cnt >= SUPER_CNT_W'(SUPER_SLOTS)) begin
                                ld_status = ST_FULL;
                            end else begin
                                super_we    = 1'b1;
                                n_super_cnt = r_super_cnt + 1'b1;
                            end
                        end
                        OP_POP_PAGE: begin
                            if (r_page_cnt == '0) begin
                                ld_out    = 1'b1;
                                ld_status = ST_EMPTY;
                            end else begin
                                page_re    = 1'b1;
                                n_page_cnt = r_page_cnt - 1'b1;
                                page_idx   = n_page_cnt[PAGE_IDX_W-1:0];
                            end
                        end
                        OP_POP_SUPER: begin
                            if (r_super_cnt == '0) begin
                                ld_out    = 1'b1;
                                ld_status = ST_EMPTY;
                            end else begin
                                super_re    = 1'b1;
                                n_super_cnt = r_super_cnt - 1'b1;
                                super_idx   = n_super_cnt[SUPER_IDX_W-1:0];
                            end
                        end
                        default: begin
                            ld_out    = 1'b1;
                            ld_status = ST_BADADDR;
                        end
                    endcase
                end
            end
            BK_READ: begin
                if (out_free) begin
                    ld_out   = 1'b1;
                    ld_frame = r_rd_super ? {r_super_rd, {SUPER_SHIFT{1'b0}}}
                                          : {r_page_rd, {PAGE_SHIFT{1'b0}}};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (page_we) begin
            r_page_mem[page_idx] <= i_q_op.frame[PAGE_FRAME_W-1:0];
        end
        if (page_re) begin
            r_page_rd <= r_page_mem[page_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (super_we) begin
            r_super_mem[super_idx] <= i_q_op.frame[SUPER_FRAME_W-1:0];
        end
        if (super_re) begin
            r_super_rd <= r_super_mem[super_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_page_cnt  <= '0;
            r_super_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_page_cnt  <= n_page_cnt;
            r_super_cnt <= n_super_cnt;
            if (ld_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (page_re || super_re) begin
            r_rd_super <= super_re;
        end
        if (ld_out) begin
            r_out_status <= ld_status;
            r_out_frame  <= ld_frame;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_frame_addr = r_out_frame;

`ifndef SYNTHESIS
    a_page_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_page_cnt <= PAGE_CNT_W'(PAGE_SLOTS))
        else $error("page count beyond capacity");

    a_super_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_super_cnt <= SUPER_CNT_W'(SUPER_SLOTS))
        else $error("superpage count beyond capacity");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !ld_out)
        else $error("stalled result overwritten");

    a_read_then_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (page_re || super_re) |=> (r_state == BK_READ && !o_q_pop))
        else $error("pop read not followed by result stage");
`endif

endmodule

[hw/rtl/two_size_page_frame_allocator.sv]
// Top level of the two-size page frame allocator.
//
// Commands come in on i_valid / o_stall with i_cmd and i_addr: free a small
// page, free a superpage, allocate a small page or allocate a superpage.
// Every command gives one result on o_valid / i_stall with o_status and
// o_frame_addr. Range registers are written through i_cfg_we, i_cfg_idx and
// i_cfg_data; the user must write them only while no command is in flight,
// which the block itself does not enforce. Frees and failed allocations pass
// through the queue and the result register; a successful allocation also
// passes the registered read of the frame stack memory. Throughput: one free
// per cycle while the receiver does not stall; an allocation holds the back
// end in its read-then-deliver sequence until its frame is delivered.
// A two-entry queue separates decode from the stacks, so commands keep being
// accepted while a result waits; when the receiver stalls, the result
// register holds, then the queue fills and o_stall rises.
// Reset empties both stacks at once (counts to zero, no clearing pass) and
// loads the range registers with their defaults.
module two_size_page_frame_allocator
    import tspfa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ADDR_W-1:0]    i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic [ADDR_W-1:0]    i_addr,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [STATUS_W-1:0]  o_status,
    output logic [ADDR_W-1:0]    o_frame_addr
);

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;
    t_op  front_op;
    t_op  head_op;

    tspfa_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_cmd      (i_cmd),
        .i_addr     (i_addr),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_op       (front_op)
    );

    tspfa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (front_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_op    (head_op)
    );

    tspfa_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_op       (head_op),
        .o_q_pop      (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_frame_addr (o_frame_addr)
    );

endmodule
